### hw/rtl/cltm_pkg.sv
// Shared types and codes for the caching lock table manager.
`timescale 1ns / 1ps

package cltm_pkg;

  typedef enum logic {
    REQ_ACQUIRE = 1'b0,
    REQ_RELEASE = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_LOCKED  = 2'd1,
    ST_WAITING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CB_NONE   = 2'd0,
    CB_REVOKE = 2'd1,
    CB_RETRY  = 2'd2
  } cb_kind_t;

  typedef enum logic {
    REPLY_OK    = 1'b0,
    REPLY_RETRY = 1'b1
  } reply_t;

  localparam int LockIdW = 8;
  localparam int ClientW = 4;

  typedef struct packed {
    req_kind_t            req_type;
    logic [LockIdW-1:0]   lock_id;
    logic [ClientW-1:0]   client_id;
  } req_t;

  typedef struct packed {
    reply_t               reply_code;
    cb_kind_t             callback_kind;
    logic [ClientW-1:0]   callback_client;
  } rsp_t;

endpackage

### hw/rtl/caching_lock_table_manager.sv
// Top level of the caching lock table manager: lock table, update logic and result register.
`timescale 1ns / 1ps

// Lock table for a caching lock manager with revoke and retry orders. Each request beat
// (acquire or release of one lock by one client) yields exactly one result beat: a reply
// code and at most one callback order. One request is taken per cycle while req_stall is
// low. The table is read into a register at the edge that takes the request; the table
// update and the result register are written when that request advances; a stall on the
// result side holds both stages.
// A request that hits the lock updated by the previous request sees that update through
// a forwarding register. After reset the table is cleared one entry per cycle, during
// which no request is taken. lock_id is reduced modulo LOCK_SLOTS and client_id modulo
// CLIENT_COUNT.
module caching_lock_table_manager #(
  parameter int LOCK_SLOTS   = 256,
  parameter int CLIENT_COUNT = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  cltm_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output cltm_pkg::rsp_t  rsp
);

  localparam int SlotW    = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
  localparam int ClIdxW   = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1;
  localparam int LockIds  = 1 << cltm_pkg::LockIdW;
  localparam int ClientIds = 1 << cltm_pkg::ClientW;

  typedef struct packed {
    cltm_pkg::status_t               status;
    logic                            holder_valid;
    logic [cltm_pkg::ClientW-1:0]    holder_client;
    logic                            retry_valid;
    logic [cltm_pkg::ClientW-1:0]    retry_client;
    logic [CLIENT_COUNT-1:0]         waiter_mask;
  } entry_t;

  // Modulo reduction tables, fixed at elaboration.
  logic [SlotW-1:0]             slot_lut [LockIds];
  logic [cltm_pkg::ClientW-1:0] client_lut [ClientIds];

  for (genvar g = 0; g < LockIds; g++) begin : g_slot_lut
    assign slot_lut[g] = SlotW'(g % LOCK_SLOTS);
  end
  for (genvar g = 0; g < ClientIds; g++) begin : g_client_lut
    assign client_lut[g] = cltm_pkg::ClientW'(g % CLIENT_COUNT);
  end

  function automatic logic [cltm_pkg::ClientW-1:0] lowest_waiter(
    input logic [CLIENT_COUNT-1:0] m
  );
    logic [cltm_pkg::ClientW-1:0] r;
    r = '0;
    for (int i = CLIENT_COUNT - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = cltm_pkg::ClientW'(i);
      end
    end
    return r;
  endfunction

  entry_t mem [LOCK_SLOTS];

  logic                          clearing;
  logic [SlotW-1:0]              clr_idx;
  logic                          s1_valid;
  cltm_pkg::req_kind_t           s1_kind;
  logic [SlotW-1:0]              s1_slot;
  logic [cltm_pkg::ClientW-1:0]  s1_cl;
  entry_t                        rd_data;
  logic                          fwd;
  entry_t                        fwd_data;

  logic                          s1_adv;
  logic                          req_accept;
  logic [SlotW-1:0]              slot_in;
  entry_t                        ent;
  entry_t                        ent_next;
  cltm_pkg::rsp_t                rsp_next;
  logic [CLIENT_COUNT-1:0]       bit_cl;
  logic [CLIENT_COUNT-1:0]       mask_left;
  logic                          target_waiting;

  assign s1_adv     = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall  = clearing || (s1_valid && !s1_adv);
  assign req_accept = req_valid && !req_stall;
  assign slot_in    = slot_lut[req.lock_id];

  assign ent            = fwd ? fwd_data : rd_data;
  assign bit_cl         = CLIENT_COUNT'(1) << s1_cl;
  assign mask_left      = ent.waiter_mask & ~bit_cl;
  assign target_waiting = ent.retry_valid && ent.waiter_mask[ClIdxW'(ent.retry_client)];

  always_comb begin
    ent_next                 = ent;
    rsp_next.reply_code      = cltm_pkg::REPLY_OK;
    rsp_next.callback_kind   = cltm_pkg::CB_NONE;
    rsp_next.callback_client = '0;
    if (s1_kind == cltm_pkg::REQ_ACQUIRE) begin
      unique case (ent.status)
        cltm_pkg::ST_FREE: begin
          ent_next.status        = cltm_pkg::ST_LOCKED;
          ent_next.holder_valid  = 1'b1;
          ent_next.holder_client = s1_cl;
        end
        cltm_pkg::ST_LOCKED: begin
          ent_next.status        = cltm_pkg::ST_WAITING;
          ent_next.waiter_mask   = ent.waiter_mask | bit_cl;
          ent_next.retry_valid   = 1'b1;
          ent_next.retry_client  = s1_cl;
          rsp_next.reply_code    = cltm_pkg::REPLY_RETRY;
          rsp_next.callback_kind = cltm_pkg::CB_REVOKE;
        end
        cltm_pkg::ST_WAITING: begin
          if (target_waiting && ent.retry_client == s1_cl) begin
            ent_next.holder_valid  = 1'b1;
            ent_next.holder_client = s1_cl;
            ent_next.waiter_mask   = mask_left;
            if (mask_left == '0) begin
              ent_next.retry_valid  = 1'b0;
              ent_next.retry_client = '0;
              ent_next.status       = cltm_pkg::ST_LOCKED;
            end else begin
              ent_next.retry_valid   = 1'b1;
              ent_next.retry_client  = lowest_waiter(mask_left);
              rsp_next.callback_kind = cltm_pkg::CB_REVOKE;
            end
          end else begin
            ent_next.waiter_mask = ent.waiter_mask | bit_cl;
            rsp_next.reply_code  = cltm_pkg::REPLY_RETRY;
          end
        end
        default: begin
          // unused status code: leave the entry alone
        end
      endcase
      // Revoke goes to the holder as it stands after the update; drop it if none.
      if (rsp_next.callback_kind == cltm_pkg::CB_REVOKE) begin
        if (ent_next.holder_valid) begin
          rsp_next.callback_client = ent_next.holder_client;
        end else begin
          rsp_next.callback_kind = cltm_pkg::CB_NONE;
        end
      end
    end else begin
      if (ent.holder_valid && ent.holder_client == s1_cl) begin
        if (ent.status == cltm_pkg::ST_LOCKED) begin
          ent_next.status        = cltm_pkg::ST_FREE;
          ent_next.holder_valid  = 1'b0;
          ent_next.holder_client = '0;
        end else if (ent.status == cltm_pkg::ST_WAITING) begin
          ent_next.holder_valid  = 1'b0;
          ent_next.holder_client = '0;
          if (ent.retry_valid) begin
            rsp_next.callback_kind   = cltm_pkg::CB_RETRY;
            rsp_next.callback_client = ent.retry_client;
          end
        end
      end
    end
  end

  // Table: one write port (clearing pass or update), one registered read port.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (s1_adv) begin
      mem[s1_slot] <= ent_next;
    end
    if (req_accept) begin
      rd_data <= mem[slot_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_idx   <= '0;
      s1_valid  <= 1'b0;
      fwd       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_idx == SlotW'(LOCK_SLOTS - 1)) begin
          clearing <= 1'b0;
        end
        clr_idx <= clr_idx + 1'b1;
      end
      if (req_accept) begin
        s1_valid <= 1'b1;
        // the read raced the write of the same entry: take the fresh copy
        fwd      <= s1_adv && (slot_in == s1_slot);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers: capture the request on accept and the result on advance, hold otherwise.
  always_ff @(posedge clk) begin
    if (req_accept) begin
      s1_kind  <= req.req_type;
      s1_slot  <= slot_in;
      s1_cl    <= client_lut[req.client_id];
      fwd_data <= ent_next;
    end
    if (s1_adv) begin
      rsp <= rsp_next;
    end
  end

endmodule

### sim/cltm_lock_checker.sv
// Lock table predictor and result checker for the caching lock table manager testbench.
`timescale 1ns / 1ps

module cltm_lock_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  cltm_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  cltm_pkg::rsp_t rsp,
  output int             fail_count,
  output int             pending
);

  localparam int Slots   = 256;
  localparam int Clients = 16;

  cltm_pkg::status_t lock_st  [Slots];
  logic              hold_v   [Slots];
  logic [3:0]        hold_c   [Slots];
  logic              retry_v  [Slots];
  logic [3:0]        retry_c  [Slots];
  logic [15:0]       waiters  [Slots];

  cltm_pkg::rsp_t expected_replies[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Apply one request to the shadow table and return the reply it should give.
  function automatic cltm_pkg::rsp_t predict_lock_reply(input cltm_pkg::req_t beat);
    logic [7:0]        slot;
    logic [3:0]        cl;
    logic [15:0]       bit_m;
    logic              target_waiting;
    cltm_pkg::status_t st;
    cltm_pkg::rsp_t    r;
    slot  = beat.lock_id;
    cl    = beat.client_id;
    bit_m = 16'b1 << cl;
    st    = lock_st[slot];
    r.reply_code      = cltm_pkg::REPLY_OK;
    r.callback_kind   = cltm_pkg::CB_NONE;
    r.callback_client = '0;
    if (beat.req_type == cltm_pkg::REQ_ACQUIRE) begin
      case (st)
        cltm_pkg::ST_FREE: begin
          lock_st[slot] = cltm_pkg::ST_LOCKED;
          hold_v[slot]  = 1'b1;
          hold_c[slot]  = cl;
        end
        cltm_pkg::ST_LOCKED: begin
          lock_st[slot]   = cltm_pkg::ST_WAITING;
          waiters[slot]   = waiters[slot] | bit_m;
          retry_v[slot]   = 1'b1;
          retry_c[slot]   = cl;
          r.reply_code    = cltm_pkg::REPLY_RETRY;
          r.callback_kind = cltm_pkg::CB_REVOKE;
        end
        cltm_pkg::ST_WAITING: begin
          target_waiting = retry_v[slot] && waiters[slot][retry_c[slot]];
          if (target_waiting && retry_c[slot] == cl) begin
            hold_v[slot]  = 1'b1;
            hold_c[slot]  = cl;
            waiters[slot] = waiters[slot] & ~bit_m;
            if (waiters[slot] == '0) begin
              retry_v[slot] = 1'b0;
              retry_c[slot] = '0;
              lock_st[slot] = cltm_pkg::ST_LOCKED;
            end else begin
              // next target is the lowest-numbered waiter
              for (int i = Clients - 1; i >= 0; i--) begin
                if (waiters[slot][i]) retry_c[slot] = 4'(i);
              end
              retry_v[slot]   = 1'b1;
              r.callback_kind = cltm_pkg::CB_REVOKE;
            end
          end else begin
            waiters[slot] = waiters[slot] | bit_m;
            r.reply_code  = cltm_pkg::REPLY_RETRY;
          end
        end
        default: ;
      endcase
      if (r.callback_kind == cltm_pkg::CB_REVOKE) begin
        if (hold_v[slot]) r.callback_client = hold_c[slot];
        else r.callback_kind = cltm_pkg::CB_NONE;
      end
    end else if (hold_v[slot] && hold_c[slot] == cl) begin
      if (st == cltm_pkg::ST_LOCKED) begin
        lock_st[slot] = cltm_pkg::ST_FREE;
        hold_v[slot]  = 1'b0;
        hold_c[slot]  = '0;
      end else if (st == cltm_pkg::ST_WAITING) begin
        hold_v[slot] = 1'b0;
        hold_c[slot] = '0;
        if (retry_v[slot]) begin
          r.callback_kind   = cltm_pkg::CB_RETRY;
          r.callback_client = retry_c[slot];
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cltm_pkg::rsp_t want;
    if (rst) begin
      for (int i = 0; i < Slots; i++) begin
        lock_st[i] = cltm_pkg::ST_FREE;
        hold_v[i]  = 1'b0;
        hold_c[i]  = '0;
        retry_v[i] = 1'b0;
        retry_c[i] = '0;
        waiters[i] = '0;
      end
      expected_replies.delete();
      fail_count = 0;
    end else begin
      // pop before push: a result never answers a request taken at the same edge
      if (rsp_valid && !rsp_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result beat with nothing expected", int'(rsp), 0);
        end else begin
          want = expected_replies.pop_front();
          if (rsp.reply_code != want.reply_code)
            report_mismatch("reply_code", int'(rsp.reply_code), int'(want.reply_code));
          if (rsp.callback_kind != want.callback_kind)
            report_mismatch("callback_kind", int'(rsp.callback_kind),
                            int'(want.callback_kind));
          if (rsp.callback_client != want.callback_client)
            report_mismatch("callback_client", int'(rsp.callback_client),
                            int'(want.callback_client));
        end
      end
      if (req_valid && !req_stall) expected_replies.push_back(predict_lock_reply(req));
    end
    pending = expected_replies.size();
  end

endmodule

### sim/tb_caching_lock_table_manager.sv
// Stimulus, flow control and verdict for the caching lock table manager.
`timescale 1ns / 1ps

module tb_caching_lock_table_manager;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 1250;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS
  } stall_mode_t;

  logic           clk;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  cltm_pkg::req_t req       = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  cltm_pkg::rsp_t rsp;

  int fail_count;
  int pending;
  int cycle_count = 0;

  cltm_pkg::req_t lock_ops[$];
  int             directed_len;
  logic [7:0]     hot_lock [4];
  stall_mode_t    stall_mode = STALL_NONE;
  int             mode_left  = 0;
  int             stall_run  = 0;

  caching_lock_table_manager u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  cltm_lock_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side back-pressure: free flow, random stalls, or runs of stalls.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STALL_NONE:   rsp_stall <= 1'b0;
      STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (stall_run == 0 && $urandom_range(0, 5) == 0) stall_run = $urandom_range(1, 8);
        rsp_stall <= (stall_run != 0);
        if (stall_run != 0) stall_run--;
      end
    endcase
  end

  function automatic cltm_pkg::req_t lock_op(input cltm_pkg::req_kind_t kind,
                                             input logic [7:0] lock,
                                             input logic [3:0] client);
    cltm_pkg::req_t r;
    r.req_type  = kind;
    r.lock_id   = lock;
    r.client_id = client;
    return r;
  endfunction

  function automatic logic [7:0] pick_lock();
    if ($urandom_range(0, 9) < 8) return hot_lock[2'($urandom_range(0, 3))];
    return 8'($urandom_range(0, 255));
  endfunction

  // Holder, contender and optional second contender hand a lock round in order.
  task automatic add_handoff();
    logic [7:0] lk;
    logic [3:0] a, b, c;
    logic       third;
    lk    = pick_lock();
    a     = 4'($urandom_range(0, 15));
    b     = 4'($urandom_range(0, 15));
    c     = 4'($urandom_range(0, 15));
    third = 1'($urandom_range(0, 1));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, lk, a));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, lk, b));
    if (third) lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, lk, c));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_RELEASE, lk, a));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, lk, b));
    if (third) begin
      lock_ops.push_back(lock_op(cltm_pkg::REQ_RELEASE, lk, b));
      lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, lk, c));
      lock_ops.push_back(lock_op(cltm_pkg::REQ_RELEASE, lk, c));
    end else begin
      lock_ops.push_back(lock_op(cltm_pkg::REQ_RELEASE, lk, b));
    end
  endtask

  task automatic send_beat(input cltm_pkg::req_t beat);
    req       <= beat;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  initial begin
    int   burst_left;
    int   gap;
    logic drain;

    // grant, revoke, plain wait, stray release, retry order, handoff chains
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, 8'd0, 4'd0));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, 8'd0, 4'd15));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, 8'd0, 4'd3));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_RELEASE, 8'd0, 4'd5));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_RELEASE, 8'd0, 4'd0));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, 8'd0, 4'd3));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, 8'd0, 4'd15));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_RELEASE, 8'd0, 4'd15));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, 8'd0, 4'd3));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_RELEASE, 8'd0, 4'd3));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_RELEASE, 8'd0, 4'd3));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_RELEASE, 8'd7, 4'd0));
    // holder asking again for its own lock
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, 8'd255, 4'd15));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, 8'd255, 4'd15));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, 8'd255, 4'd15));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_RELEASE, 8'd255, 4'd15));
    // interleave two locks so forwarding must not mix them up
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, 8'd128, 4'd9));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, 8'd129, 4'd6));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, 8'd128, 4'd6));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_ACQUIRE, 8'd129, 4'd9));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_RELEASE, 8'd128, 4'd9));
    lock_ops.push_back(lock_op(cltm_pkg::REQ_RELEASE, 8'd129, 4'd6));
    directed_len = lock_ops.size();

    for (int i = 0; i < 4; i++) hot_lock[i] = 8'($urandom_range(0, 255));
    while (lock_ops.size() < directed_len + RandomItems) begin
      if ($urandom_range(0, 9) < 6) begin
        add_handoff();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0)
            lock_ops.push_back(lock_op(cltm_pkg::req_kind_t'($urandom_range(0, 1)),
                                       8'($urandom_range(0, 255)),
                                       4'($urandom_range(0, 15))));
          else
            lock_ops.push_back(lock_op(cltm_pkg::req_kind_t'($urandom_range(0, 1)),
                                       pick_lock(), 4'($urandom_range(0, 3))));
        end
      end
    end

    @(posedge clk);
    @(negedge clk);
    while (rst) @(negedge clk);

    burst_left = 0;
    for (int n = 0; n < lock_ops.size(); n++) begin
      drain = (n == directed_len) || (n % 300 == 299);
      if (burst_left == 0) begin
        gap        = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 40);
      end else begin
        gap = 0;
      end
      if (drain && gap == 0) gap = 1;
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
        // at a drain point, hold off until every outstanding reply is back
        while (drain && pending != 0) @(negedge clk);
      end
      send_beat(lock_ops[n]);
      burst_left--;
    end
    req_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
